// ===== hw/rtl/escaped_utf8_decoder_top_defines.svh =====
// assertion macros for the escaped utf-8 decoder
`ifndef ESCAPED_UTF8_DECODER_TOP_DEFINES_SVH
`define ESCAPED_UTF8_DECODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// checked from reset release onwards
`define ESCD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define ESCD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ESCD_ASSERT(label, clk, rst_n, prop, msg)
`define ESCD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/escd_pkg.sv =====
package escd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_CONT = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX  = 3'd3,
    PH_HASH = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_UTF8   = 3'd1,
    ST_BAD_ESCAPE = 3'd2,
    ST_BAD_HEX    = 3'd3,
    ST_OPEN_HASH  = 3'd4,
    ST_HASH_CHAR  = 3'd5
  } status_e;

  typedef struct packed {
    logic        emit;
    logic [31:0] code_point;
    status_e     status;
  } res_t;

  localparam logic [31:0] SLASH_RESET = 32'd47;
  localparam logic [31:0] FNV_BASIS   = 32'h811C_9DC5;
  localparam logic [31:0] HASH_FLAG   = 32'h8000_0000;

  // escape and hash characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_UPPER_U = 8'h55;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_PRINT_LO = 8'h21;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  // {valid, value} of one hex digit, either letter case
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  // x * 16777619 = x * (2^24 + 256 + 128 + 16 + 2 + 1), mod 2^32
  function automatic logic [31:0] fnv_mul(input logic [31:0] x);
    return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// ===== hw/rtl/escd_in_stage.sv =====
module escd_in_stage
  import escd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] byte_i,
  input  logic       advance_i,
  output logic       full_o,
  output logic [7:0] byte_o
);

  logic       full_q, full_d;
  logic [7:0] byte_q;
  logic       take;

  assign stall_o = full_q & ~advance_i;
  assign take    = valid_i & ~stall_o;
  assign full_d  = take | (full_q & ~advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= byte_i;
    end
  end

  assign full_o = full_q;
  assign byte_o = byte_q;

endmodule

// ===== hw/rtl/escd_decode.sv =====
module escd_decode
  import escd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic [31:0] slash_code_i,
  output res_t        res_o,
  output phase_e      phase_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  digits_q, digits_d;
  logic [31:0] acc_q, acc_d;
  logic [3:0]  digits_dec;
  logic [4:0]  hexv;
  res_t        res;

  always_comb begin
    phase_d    = phase_q;
    digits_d   = digits_q;
    acc_d      = acc_q;
    res        = '{emit: 1'b0, code_point: 32'd0, status: ST_OK};
    digits_dec = digits_q - 4'd1;
    hexv       = hex_digit(byte_i);

    unique case (phase_q)
      PH_CONT: begin
        if (byte_i[7:6] != 2'b10) begin
          res.emit   = 1'b1;
          res.status = ST_BAD_UTF8;
        end else begin
          acc_d    = {acc_q[25:0], byte_i[5:0]};
          digits_d = digits_dec;
          if (digits_dec == 4'd0) begin
            res.emit       = 1'b1;
            res.code_point = acc_d;
          end
        end
      end

      PH_ESC: begin
        res.emit = 1'b1;
        unique case (byte_i)
          CH_SQUOTE, CH_DQUOTE, CH_BTICK, CH_BSLASH:
                     res.code_point = {24'd0, byte_i};
          CH_A:      res.code_point = 32'h07;
          CH_B:      res.code_point = 32'h08;
          CH_F:      res.code_point = 32'h0C;
          CH_N:      res.code_point = 32'h0A;
          CH_R:      res.code_point = 32'h0D;
          CH_T:      res.code_point = 32'h09;
          CH_V:      res.code_point = 32'h0B;
          CH_ZERO:   res.code_point = 32'h00;
          CH_SLASH:  res.code_point = slash_code_i;
          CH_X: begin
            res.emit = 1'b0;
            phase_d  = PH_HEX;
            digits_d = 4'd2;
            acc_d    = 32'd0;
          end
          CH_U: begin
            res.emit = 1'b0;
            phase_d  = PH_HEX;
            digits_d = 4'd4;
            acc_d    = 32'd0;
          end
          CH_UPPER_U: begin
            res.emit = 1'b0;
            phase_d  = PH_HEX;
            digits_d = 4'd8;
            acc_d    = 32'd0;
          end
          CH_LPAREN: begin
            res.emit = 1'b0;
            phase_d  = PH_HASH;
            digits_d = 4'd0;
            acc_d    = FNV_BASIS;
          end
          default:   res.status = ST_BAD_ESCAPE;
        endcase
      end

      PH_HEX: begin
        if (!hexv[4]) begin
          res.emit   = 1'b1;
          res.status = ST_BAD_HEX;
        end else begin
          acc_d    = {acc_q[27:0], hexv[3:0]};
          digits_d = digits_dec;
          if (digits_dec == 4'd0) begin
            res.emit       = 1'b1;
            res.code_point = acc_d;
          end
        end
      end

      PH_HASH: begin
        if (byte_i == CH_NUL) begin
          res.emit   = 1'b1;
          res.status = ST_OPEN_HASH;
        end else if (byte_i == CH_RPAREN) begin
          res.emit       = 1'b1;
          res.code_point = acc_q | HASH_FLAG;
        end else if (byte_i < CH_PRINT_LO || byte_i > CH_PRINT_HI || byte_i == CH_BSLASH) begin
          res.emit   = 1'b1;
          res.status = ST_HASH_CHAR;
        end else begin
          acc_d = fnv_mul(acc_q ^ {24'd0, byte_i});
        end
      end

      // idle, and the unused phase codes
      default: begin
        if (!byte_i[7]) begin
          if (byte_i == CH_BSLASH) begin
            phase_d  = PH_ESC;
            digits_d = 4'd0;
            acc_d    = 32'd0;
          end else begin
            res.emit       = 1'b1;
            res.code_point = {24'd0, byte_i};
          end
        end else if (byte_i[7:5] == 3'b110) begin
          phase_d  = PH_CONT;
          acc_d    = {27'd0, byte_i[4:0]};
          digits_d = 4'd1;
        end else if (byte_i[7:4] == 4'b1110) begin
          phase_d  = PH_CONT;
          acc_d    = {28'd0, byte_i[3:0]};
          digits_d = 4'd2;
        end else if (byte_i[7:3] == 5'b11110) begin
          phase_d  = PH_CONT;
          acc_d    = {29'd0, byte_i[2:0]};
          digits_d = 4'd3;
        end else begin
          res.emit   = 1'b1;
          res.status = ST_BAD_UTF8;
        end
      end
    endcase

    // any result, good or bad, ends the character
    if (res.emit) begin
      phase_d  = PH_IDLE;
      digits_d = 4'd0;
      acc_d    = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      digits_q <= 4'd0;
      acc_q    <= 32'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      digits_q <= digits_d;
      acc_q    <= acc_d;
    end
  end

  assign res_o   = res;
  assign phase_o = phase_q;

endmodule

// ===== hw/rtl/escaped_utf8_decoder_top.sv =====
// Escaped UTF-8 decoder: one source byte in per item, at most one code point out.
// Input channel: in_valid_i / in_stall_o with byte_in_i. Output channel:
// out_valid_o / out_stall_i with code_point_o and status_o (0 ok, else error
// code with code_point_o zero). An item moves on an edge with valid high and
// stall low.
// Bytes of a multi-byte character, an escape, hex digits or a hash sequence
// give no result until the character completes or fails.
// A byte goes into the input register and is decoded there against the character
// state. Any result is loaded into the output register when the decoder advances,
// which waits while a held result is stalled.
// Throughput is one byte per cycle while out_stall_i stays low: the decode path
// is a single pass; its longest leg is the FNV-1a constant multiply done as a shift-add.
// When the receiver stalls a held result, the input register keeps at most one
// byte and then in_stall_o rises until the result is taken.
// Reset empties both registers, returns to idle and sets slash_code to 47.
// cfg_we_i / cfg_data_i write slash_code; write only while idle.
`include "escaped_utf8_decoder_top_defines.svh"

module escaped_utf8_decoder_top
  import escd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] code_point_o,
  output logic [2:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i
);

  logic        in_full;
  logic [7:0]  in_byte;
  logic        advance;
  logic [31:0] slash_code_q;
  res_t        res;
  phase_e      phase;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_cp_q;
  status_e     out_st_q;
  logic        load_out;

  // decode only when the output register can take whatever comes out
  assign advance  = in_full & (~out_valid_q | ~out_stall_i);
  assign load_out = advance & res.emit;

  escd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .stall_o   (in_stall_o),
    .byte_i    (byte_in_i),
    .advance_i (advance),
    .full_o    (in_full),
    .byte_o    (in_byte)
  );

  escd_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_i       (in_byte),
    .slash_code_i (slash_code_q),
    .res_o        (res),
    .phase_o      (phase)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slash_code_q <= SLASH_RESET;
    end else if (cfg_we_i) begin
      slash_code_q <= cfg_data_i;
    end
  end

  assign out_valid_d = load_out | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_cp_q <= res.code_point;
      out_st_q <= res.status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = out_cp_q;
  assign status_o     = out_st_q;

  `ESCD_ASSERT(a_err_zero_cp, clk_i, rst_ni, (out_valid_o && status_o != ST_OK) |-> (code_point_o == 32'd0), "error item carries a nonzero code point")
  `ESCD_ASSERT(a_emit_to_idle, clk_i, rst_ni, load_out |=> (phase == PH_IDLE), "decoder not idle after a result")
  `ESCD_ASSERT(a_status_range, clk_i, rst_ni, out_valid_o |-> (status_o <= ST_HASH_CHAR), "status code out of range")
  `ESCD_ASSERT_ALWAYS(a_stall_only_full, clk_i, in_stall_o |-> in_full, "input stalled with an empty input register")

endmodule
